/* sv/assert_macros.svh */
// Assertion macros used by the checker file ifcg_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, off during reset
`define IFCG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication on the next cycle, off during reset
`define IFCG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// implication on the next cycle, checked during reset too
`define IFCG_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ifcg_pkg.sv */
// Package for the image fit/crop geometry block: defaults and register indexes.
// No dependencies.
`default_nettype none

package ifcg_pkg;

    localparam int DIM_BITS_DEF  = 12;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int DIST_W        = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORCE_RESIZE   = 3'd0,
        CFG_TARGET_WIDTH   = 3'd1,
        CFG_TARGET_HEIGHT  = 3'd2,
        CFG_MAX_DISTORTION = 3'd3,
        CFG_THUMB_ENABLE   = 3'd4,
        CFG_THUMB_LIMIT    = 3'd5
    } cfg_idx_t;

endpackage

`default_nettype wire

/* sv/ifcg_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a side bus.
// Depends on nothing; instanced by image_fit_crop_geometry.
`default_nettype none

module ifcg_div #(
    parameter int NUM_W  = 30,
    parameter int DEN_W  = 13,
    parameter int SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [NUM_W-1:0]       quo,
    output logic [SIDE_W-1:0]      side_out
);

    logic [NUM_W-1:0]  valid_reg;
    logic [NUM_W-1:0]  num_reg  [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [NUM_W-1:0]  quo_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];

    logic [NUM_W-1:0]  num_src  [NUM_W];
    logic [DEN_W-1:0]  den_src  [NUM_W];
    logic [DEN_W-1:0]  rem_src  [NUM_W];
    logic [NUM_W-1:0]  quo_src  [NUM_W];
    logic [SIDE_W-1:0] side_src [NUM_W];
    logic [DEN_W:0]    trial    [NUM_W];
    logic [DEN_W:0]    diff     [NUM_W];
    logic [NUM_W-1:0]  fit;
    logic [DEN_W-1:0]  rem_next [NUM_W];
    logic [NUM_W-1:0]  quo_next [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign num_src[k]  = num;
            assign den_src[k]  = den;
            assign rem_src[k]  = '0;
            assign quo_src[k]  = '0;
            assign side_src[k] = side_in;
        end else begin : g_next
            assign num_src[k]  = num_reg[k-1];
            assign den_src[k]  = den_reg[k-1];
            assign rem_src[k]  = rem_reg[k-1];
            assign quo_src[k]  = quo_reg[k-1];
            assign side_src[k] = side_reg[k-1];
        end
        assign trial[k]    = {rem_src[k], num_src[k][NUM_W-1-k]};
        assign diff[k]     = trial[k] - {1'b0, den_src[k]};
        assign fit[k]      = trial[k] >= {1'b0, den_src[k]};
        assign rem_next[k] = fit[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
        assign quo_next[k] = {quo_src[k][NUM_W-2:0], fit[k]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NUM_W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NUM_W; k++) begin
                num_reg[k]  <= num_src[k];
                den_reg[k]  <= den_src[k];
                rem_reg[k]  <= rem_next[k];
                quo_reg[k]  <= quo_next[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign quo       = quo_reg[NUM_W-1];
    assign side_out  = side_reg[NUM_W-1];

endmodule

`default_nettype wire

/* sv/image_fit_crop_geometry.sv */
// Pipeline: three chained bit-per-stage dividers (scale, distortion, sample size).
// Throughput: one transaction per cycle; the whole pipe halts while a result waits.
// Reset: synchronous, active low; clears valid bits and the configuration registers.
`default_nettype none

module image_fit_crop_geometry #(
    parameter int DIM_BITS  = ifcg_pkg::DIM_BITS_DEF,
    parameter int FRAC_BITS = ifcg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ifcg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ifcg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // src_width, src_height
    input  wire logic [((2*DIM_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // resize_active, sample_width, sample_height, sample_needed, crop_x, crop_y,
    // crop_needed, thumb_active, thumb_width, thumb_height
    output logic [((6*DIM_BITS+4+7)/8)*8-1:0]        m_tdata
);

    localparam int D      = DIM_BITS;
    localparam int F      = FRAC_BITS;
    localparam int OUT_W  = ((6*D+4+7)/8)*8;
    localparam int N1_W   = D + F + 2;
    localparam int N2_W   = 2*D + F + 3;
    localparam int SC_W   = D + F;
    localparam int PW_W   = 2*D + 1;
    localparam int FX_W   = F + 1;
    localparam int PS_W   = D + SC_W + 1;
    localparam int TS_W   = FX_W + D + 1;
    localparam int FXD_W  = F + ifcg_pkg::DIST_W;
    localparam int SHL    = (F >= 16) ? F - 16 : 0;
    localparam int SHR    = (F >= 16) ? 0 : 16 - F;
    localparam int S2X_W  = 2*D + PW_W + 2;
    localparam int S2Y_W  = 2*D + PW_W;
    localparam logic [FX_W-1:0] ONE_FX  = FX_W'(1) << F;
    localparam logic [PS_W-1:0] HALF_PS = PS_W'(1) << (F-1);
    localparam logic [TS_W-1:0] HALF_TS = TS_W'(1) << (F-1);
    localparam logic [D-1:0]    DIM_MAX = '1;

    // configuration
    logic                               force_reg;
    logic [D-1:0]                       tw_reg;
    logic [D-1:0]                       th_reg;
    logic [ifcg_pkg::DIST_W-1:0]        dist_reg;
    logic                               ten_reg;
    logic [D-1:0]                       lim_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            force_reg <= 1'b0;
            tw_reg    <= '0;
            th_reg    <= '0;
            dist_reg  <= '0;
            ten_reg   <= 1'b0;
            lim_reg   <= '0;
        end else if (cfg_valid) begin
            case (ifcg_pkg::cfg_idx_t'(cfg_index))
                ifcg_pkg::CFG_FORCE_RESIZE:   force_reg <= cfg_data[0];
                ifcg_pkg::CFG_TARGET_WIDTH:   tw_reg    <= cfg_data[D-1:0];
                ifcg_pkg::CFG_TARGET_HEIGHT:  th_reg    <= cfg_data[D-1:0];
                ifcg_pkg::CFG_MAX_DISTORTION: dist_reg  <= cfg_data[ifcg_pkg::DIST_W-1:0];
                ifcg_pkg::CFG_THUMB_ENABLE:   ten_reg   <= cfg_data[0];
                ifcg_pkg::CFG_THUMB_LIMIT:    lim_reg   <= cfg_data[D-1:0];
                default: ;
            endcase
        end
    end

    logic            out_valid_reg;
    logic [OUT_W-1:0] out_reg;
    logic            en;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // entry
    logic [D-1:0]    in_w, in_h, in_src_h;
    logic            in_nonempty, in_act, in_tact, in_tsmall;
    logic [N1_W-1:0] num_sx, num_sy, num_t;

    always_comb begin
        in_w        = s_tdata[D-1:0];
        in_h        = s_tdata[2*D-1:D];
        in_nonempty = (in_w != '0) && (in_h != '0);
        in_act      = force_reg && (tw_reg != '0) && (th_reg != '0) && in_nonempty &&
                      ((in_w != tw_reg) || (in_h != th_reg));
        in_tact     = ten_reg && (lim_reg != '0) && in_nonempty;
        in_src_h    = in_act ? th_reg : in_h;
        in_tsmall   = lim_reg < in_src_h;
        num_sx      = (N1_W'(tw_reg) << (F+1)) + N1_W'(in_w);
        num_sy      = (N1_W'(th_reg) << (F+1)) + N1_W'(in_h);
        num_t       = (N1_W'(lim_reg) << (F+1)) + N1_W'(in_src_h);
    end

    // scale and thumbnail factor dividers
    logic            d1_valid;
    logic [N1_W-1:0] q_sx, q_sy, q_t;
    logic [2:0]      d1_flags;
    logic [D-1:0]    d1_w, d1_h;

    ifcg_div #(.NUM_W(N1_W), .DEN_W(D+1), .SIDE_W(3)) u_div_sx (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_tvalid),
        .num(num_sx), .den({in_w, 1'b0}), .side_in({in_act, in_tact, in_tsmall}),
        .out_valid(d1_valid), .quo(q_sx), .side_out(d1_flags)
    );

    ifcg_div #(.NUM_W(N1_W), .DEN_W(D+1), .SIDE_W(D)) u_div_sy (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_tvalid),
        .num(num_sy), .den({in_h, 1'b0}), .side_in(in_h),
        .out_valid(), .quo(q_sy), .side_out(d1_h)
    );

    ifcg_div #(.NUM_W(N1_W), .DEN_W(D+1), .SIDE_W(D)) u_div_t (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_tvalid),
        .num(num_t), .den({in_src_h, 1'b0}), .side_in(in_w),
        .out_valid(), .quo(q_t), .side_out(d1_w)
    );

    // P1: larger scale
    logic            p1_valid_reg;
    logic [SC_W-1:0] p1_sc_reg;
    logic [FX_W-1:0] p1_f_reg;
    logic            p1_act_reg, p1_tact_reg, p1_tsmall_reg;
    logic [D-1:0]    p1_w_reg, p1_h_reg;

    // P2: products
    logic                 p2_valid_reg;
    logic [D+SC_W-1:0]    p2_pw_prod_reg, p2_ph_prod_reg;
    logic [FX_W+D-1:0]    p2_t_prod_reg;
    logic                 p2_act_reg, p2_tact_reg, p2_tsmall_reg;
    logic [D-1:0]         p2_w_reg, p2_h_reg;
    logic [D-1:0]         p1_src_w;

    // P3: rounded sizes, thumbnail result
    logic            p3_valid_reg;
    logic [PW_W-1:0] p3_pw_reg, p3_ph_reg;
    logic            p3_act_reg, p3_tact_reg;
    logic [D-1:0]    p3_w_reg, p3_h_reg, p3_tw_reg, p3_th_reg;
    logic [PS_W-1:0] pw_sum, ph_sum;
    logic [TS_W-1:0] t_sum;
    logic [D-1:0]    p2_src_w, p2_src_h, tw_next, th_next;

    always_comb begin
        p1_src_w = p1_act_reg ? tw_reg : p1_w_reg;
        pw_sum   = {1'b0, p2_pw_prod_reg} + HALF_PS;
        ph_sum   = {1'b0, p2_ph_prod_reg} + HALF_PS;
        t_sum    = {1'b0, p2_t_prod_reg} + HALF_TS;
        p2_src_w = p2_act_reg ? tw_reg : p2_w_reg;
        p2_src_h = p2_act_reg ? th_reg : p2_h_reg;
        if (!p2_tact_reg) begin
            tw_next = '0;
            th_next = '0;
        end else if (p2_tsmall_reg) begin
            tw_next = t_sum[F+D-1:F];
            th_next = lim_reg;
        end else begin
            tw_next = p2_src_w;
            th_next = p2_src_h;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= d1_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_sc_reg      <= (q_sy > q_sx) ? q_sy[SC_W-1:0] : q_sx[SC_W-1:0];
            p1_f_reg       <= q_t[FX_W-1:0];
            {p1_act_reg, p1_tact_reg, p1_tsmall_reg} <= d1_flags;
            p1_w_reg       <= d1_w;
            p1_h_reg       <= d1_h;

            p2_pw_prod_reg <= p1_w_reg * p1_sc_reg;
            p2_ph_prod_reg <= p1_h_reg * p1_sc_reg;
            p2_t_prod_reg  <= p1_f_reg * p1_src_w;
            p2_act_reg     <= p1_act_reg;
            p2_tact_reg    <= p1_tact_reg;
            p2_tsmall_reg  <= p1_tsmall_reg;
            p2_w_reg       <= p1_w_reg;
            p2_h_reg       <= p1_h_reg;

            p3_pw_reg      <= pw_sum[PS_W-1:F];
            p3_ph_reg      <= ph_sum[PS_W-1:F];
            p3_act_reg     <= p2_act_reg;
            p3_tact_reg    <= p2_tact_reg;
            p3_w_reg       <= p2_w_reg;
            p3_h_reg       <= p2_h_reg;
            p3_tw_reg      <= tw_next;
            p3_th_reg      <= th_next;
        end
    end

    // distortion dividers
    logic             d2_valid;
    logic [N2_W-1:0]  q_dx, q_dy;
    logic [S2X_W-1:0] d2x_side;
    logic [S2Y_W-1:0] d2y_side;

    ifcg_div #(.NUM_W(N2_W), .DEN_W(D+1), .SIDE_W(S2X_W)) u_div_dx (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(p3_valid_reg),
        .num((N2_W'(p3_pw_reg) << (F+1)) + N2_W'(tw_reg)), .den({tw_reg, 1'b0}),
        .side_in({p3_act_reg, p3_w_reg, p3_pw_reg, p3_tact_reg, p3_tw_reg}),
        .out_valid(d2_valid), .quo(q_dx), .side_out(d2x_side)
    );

    ifcg_div #(.NUM_W(N2_W), .DEN_W(D+1), .SIDE_W(S2Y_W)) u_div_dy (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(p3_valid_reg),
        .num((N2_W'(p3_ph_reg) << (F+1)) + N2_W'(th_reg)), .den({th_reg, 1'b0}),
        .side_in({p3_h_reg, p3_ph_reg, p3_th_reg}),
        .out_valid(), .quo(q_dy), .side_out(d2y_side)
    );

    // P4: clamp distortion
    logic            d2_act, d2_tact;
    logic [D-1:0]    d2_w, d2_h, d2_tw, d2_th;
    logic [PW_W-1:0] d2_pw, d2_ph;
    logic [FX_W-1:0] dist_fx, lo_fx, hi_fx, dx_next, dy_next;

    assign {d2_act, d2_w, d2_pw, d2_tact, d2_tw} = d2x_side;
    assign {d2_h, d2_ph, d2_th} = d2y_side;

    always_comb begin
        dist_fx = FX_W'((FXD_W'(dist_reg) << SHL) >> SHR);
        lo_fx   = ONE_FX - dist_fx;
        hi_fx   = ONE_FX + dist_fx;
        if (q_dx < N2_W'(lo_fx)) begin
            dx_next = lo_fx;
        end else if (q_dx > N2_W'(hi_fx)) begin
            dx_next = hi_fx;
        end else begin
            dx_next = q_dx[FX_W-1:0];
        end
        if (q_dy < N2_W'(lo_fx)) begin
            dy_next = lo_fx;
        end else if (q_dy > N2_W'(hi_fx)) begin
            dy_next = hi_fx;
        end else begin
            dy_next = q_dy[FX_W-1:0];
        end
    end

    logic            p4_valid_reg;
    logic [FX_W-1:0] p4_dx_reg, p4_dy_reg;
    logic            p4_act_reg, p4_tact_reg;
    logic [D-1:0]    p4_w_reg, p4_h_reg, p4_tw_reg, p4_th_reg;
    logic [PW_W-1:0] p4_pw_reg, p4_ph_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_valid_reg <= 1'b0;
        end else if (en) begin
            p4_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p4_dx_reg   <= dx_next;
            p4_dy_reg   <= dy_next;
            p4_act_reg  <= d2_act;
            p4_tact_reg <= d2_tact;
            p4_w_reg    <= d2_w;
            p4_h_reg    <= d2_h;
            p4_tw_reg   <= d2_tw;
            p4_th_reg   <= d2_th;
            p4_pw_reg   <= d2_pw;
            p4_ph_reg   <= d2_ph;
        end
    end

    // sample size dividers
    logic            d3_valid;
    logic [N2_W-1:0] q_sw, q_sh;
    logic [2*D+1:0]  d3x_side;
    logic [2*D-1:0]  d3y_side;

    ifcg_div #(.NUM_W(N2_W), .DEN_W(FX_W+1), .SIDE_W(2*D+2)) u_div_sw (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(p4_valid_reg),
        .num((N2_W'(p4_pw_reg) << (F+1)) + N2_W'(p4_dx_reg)), .den({p4_dx_reg, 1'b0}),
        .side_in({p4_act_reg, p4_w_reg, p4_tact_reg, p4_tw_reg}),
        .out_valid(d3_valid), .quo(q_sw), .side_out(d3x_side)
    );

    ifcg_div #(.NUM_W(N2_W), .DEN_W(FX_W+1), .SIDE_W(2*D)) u_div_sh (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(p4_valid_reg),
        .num((N2_W'(p4_ph_reg) << (F+1)) + N2_W'(p4_dy_reg)), .den({p4_dy_reg, 1'b0}),
        .side_in({p4_h_reg, p4_th_reg}),
        .out_valid(), .quo(q_sh), .side_out(d3y_side)
    );

    // P5: saturate
    logic         p5_valid_reg;
    logic [D-1:0] p5_sw_reg, p5_sh_reg;
    logic         p5_act_reg, p5_tact_reg;
    logic [D-1:0] p5_w_reg, p5_h_reg, p5_tw_reg, p5_th_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p5_valid_reg <= 1'b0;
        end else if (en) begin
            p5_valid_reg <= d3_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p5_sw_reg <= (q_sw > N2_W'(DIM_MAX)) ? DIM_MAX : q_sw[D-1:0];
            p5_sh_reg <= (q_sh > N2_W'(DIM_MAX)) ? DIM_MAX : q_sh[D-1:0];
            {p5_act_reg, p5_w_reg, p5_tact_reg, p5_tw_reg} <= d3x_side;
            {p5_h_reg, p5_th_reg} <= d3y_side;
        end
    end

    // P6: flags, crop offsets, output register
    logic         s_need, c_need;
    logic [D-1:0] crop_x, crop_y, ex_w, ex_h;
    logic [D-1:0] sw_o, sh_o;

    always_comb begin
        ex_w   = p5_sw_reg - tw_reg;
        ex_h   = p5_sh_reg - th_reg;
        s_need = p5_act_reg && ((p5_sw_reg != p5_w_reg) || (p5_sh_reg != p5_h_reg));
        c_need = p5_act_reg && ((p5_sw_reg != tw_reg) || (p5_sh_reg != th_reg));
        crop_x = (p5_act_reg && (p5_sw_reg > tw_reg)) ? (ex_w >> 1) : '0;
        crop_y = (p5_act_reg && (p5_sh_reg > th_reg)) ? (ex_h >> 1) : '0;
        sw_o   = p5_act_reg ? p5_sw_reg : '0;
        sh_o   = p5_act_reg ? p5_sh_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= p5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= OUT_W'({p5_th_reg, p5_tw_reg, p5_tact_reg, c_need, crop_y, crop_x,
                               s_need, sh_o, sw_o, p5_act_reg});
        end
    end

endmodule

`default_nettype wire

/* sv/ifcg_checker.sv */
// Port-level checks for image_fit_crop_geometry, bound to the top level.
// Depends on assert_macros.svh and ifcg_pkg.
`default_nettype none
`include "assert_macros.svh"

module ifcg_checker #(
    parameter int DIM_BITS = ifcg_pkg::DIM_BITS_DEF
) (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_tready,
    input wire logic                                 m_tvalid,
    input wire logic                                 m_tready,
    input wire logic [((6*DIM_BITS+4+7)/8)*8-1:0]    m_tdata
);

    localparam int D = DIM_BITS;

    `IFCG_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `IFCG_ASSERT_IMP(a_resize_off_zero, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[4*D+2:1] == '0, "resize fields set while inactive")
    `IFCG_ASSERT_IMP(a_thumb_off_zero, aclk, aresetn, m_tvalid && !m_tdata[4*D+3], m_tdata[6*D+3:4*D+4] == '0, "thumbnail fields set while inactive")
    `IFCG_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready, "input stalled with empty output")
    `IFCG_ASSERT_NXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_tvalid, "output valid after reset")

endmodule

bind image_fit_crop_geometry ifcg_checker #(.DIM_BITS(DIM_BITS)) u_ifcg_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

`default_nettype wire
